// File: hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 keystream generator.
package rc4_pkg;

	localparam int KEY_DEPTH_DEF = 256;
	localparam int SBOX_DEPTH    = 256;
	localparam int KLEN_W        = 9;
	localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_SCHED  = 2'd1;
	localparam logic [1:0] MODE_STREAM = 2'd2;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_KEYED = 1'b1;

	localparam int REG_KLEN = 0;

	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
		logic [7:0] key_index;
		logic [7:0] key_byte;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] stream_byte;
		logic       status;
	} res_t;

endpackage

// File: hw/rtl/rc4_keystream_generator_unit.sv
// Top level of the RC4 keystream generator: config register, stream ports, output stage.
//
// channel   dir  transfer when              payload
// s_axis    in   s_axis_tvalid & tready      tdata {key_byte, key_index}, tuser mode
// m_axis    out  m_axis_tvalid & tready      tdata stream_byte, tuser status
// apb       in   psel & penable & pwrite     key length register at byte address 0
//
// Key load: a key byte is written to the key store. Keystream byte: 5 single-port S-box accesses.
// Key schedule: a 256-entry S-box fill, then 256 swap steps, bound by the single S-box port.
// Not-keyed request: zero byte. Reset leaves the block not keyed, key length 16.
// A result waits in the output register; the sequencer holds its last step until it drains.
module rc4_keystream_generator_unit #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] key_index, [15:8] key_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] stream_byte
	output logic [0:0]  m_axis_tuser,   // [0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [rc4_pkg::KLEN_W-1:0] klen_q;
	logic [rc4_pkg::KLEN_W-1:0] key_len_eff;
	logic                       cfg_sel;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       out_status_q;
	logic                       out_free;
	logic                       core_idle;
	logic                       core_keyed;
	rc4_pkg::cmd_t              cmd;
	rc4_pkg::res_t              res;

	assign cfg_sel = (paddr[2] == 1'(rc4_pkg::REG_KLEN));
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? {23'd0, klen_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= rc4_pkg::KLEN_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			klen_q <= pwdata[rc4_pkg::KLEN_W-1:0];
		end
	end

	always_comb begin
		priority if (klen_q == '0) begin
			key_len_eff = rc4_pkg::KLEN_W'(1);
		end else if (klen_q > rc4_pkg::KLEN_W'(KEY_DEPTH)) begin
			key_len_eff = rc4_pkg::KLEN_W'(KEY_DEPTH);
		end else begin
			key_len_eff = klen_q;
		end
	end

	assign s_axis_tready = core_idle;
	assign cmd.valid     = s_axis_tvalid && s_axis_tready;
	assign cmd.mode      = s_axis_tuser;
	assign cmd.key_index = s_axis_tdata[7:0];
	assign cmd.key_byte  = s_axis_tdata[15:8];

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_byte_q   <= res.stream_byte;
			out_status_q <= res.status;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_byte_q;
	assign m_axis_tuser[0] = out_status_q;

	rc4_core #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key_len  (key_len_eff),
		.out_free (out_free),
		.idle     (core_idle),
		.keyed    (core_keyed),
		.res      (res)
	);

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!out_valid_q || m_axis_tready))
		else $error("result loaded over a pending transfer");

	// schedule and keystream requests leave idle on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && (cmd.mode == rc4_pkg::MODE_SCHED || cmd.mode == rc4_pkg::MODE_STREAM))
		|=> !core_idle)
		else $error("sequencer did not start on request");

	// a valid keystream byte only comes from a keyed engine
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == rc4_pkg::STATUS_OK) |-> core_keyed)
		else $error("keystream byte produced before key schedule");

	// not-keyed status carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == rc4_pkg::STATUS_NOT_KEYED) |-> (res.stream_byte == 8'd0))
		else $error("not-keyed result with nonzero byte");

endmodule

// File: hw/rtl/rc4_ram.sv
// Generic single-port RAM with registered read (read-before-write).
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/rc4_core.sv
// RC4 sequencer: key store and S-box memories, key schedule and output step.
module rc4_core #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rc4_pkg::cmd_t             cmd,
	input  logic [rc4_pkg::KLEN_W-1:0] key_len,
	input  logic                      out_free,
	output logic                      idle,
	output logic                      keyed,
	output rc4_pkg::res_t             res
);

	localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FILL  = 4'd1;
	localparam logic [3:0] ST_KRD   = 4'd2;
	localparam logic [3:0] ST_KACC  = 4'd3;
	localparam logic [3:0] ST_KWK   = 4'd4;
	localparam logic [3:0] ST_KWA   = 4'd5;
	localparam logic [3:0] ST_PRD_I = 4'd6;
	localparam logic [3:0] ST_PRD_J = 4'd7;
	localparam logic [3:0] ST_PRD_T = 4'd8;
	localparam logic [3:0] ST_PWR_I = 4'd9;
	localparam logic [3:0] ST_PWR_J = 4'd10;
	localparam logic [3:0] ST_NKEY  = 4'd11;

	logic [3:0]        state_q;
	logic [7:0]        k_q;
	logic [KEY_AW-1:0] kk_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic              keyed_q;
	logic [7:0]        a_q;
	logic [7:0]        b_q;
	logic [7:0]        c_q;
	logic [7:0]        t_q;

	logic              s_we;
	logic [7:0]        s_addr;
	logic [7:0]        s_wdata;
	logic [7:0]        s_rdata;
	logic              k_we;
	logic [KEY_AW-1:0] k_addr;
	logic [7:0]        k_rdata;

	logic [7:0]        acc_nxt;
	logic [7:0]        jp_nxt;
	logic [7:0]        t_nxt;
	logic              kk_wrap;
	logic              key_in_range;

	assign acc_nxt      = j_q + s_rdata + k_rdata;
	assign jp_nxt       = j_q + s_rdata;
	assign t_nxt        = a_q + s_rdata;
	assign kk_wrap      = (rc4_pkg::KLEN_W'(kk_q) + 9'd1) == key_len;
	assign key_in_range = {1'b0, cmd.key_index} < rc4_pkg::KLEN_W'(KEY_DEPTH);

	assign idle  = (state_q == ST_IDLE);
	assign keyed = keyed_q;

	// S-box port
	always_comb begin
		s_we    = 1'b0;
		s_addr  = k_q;
		s_wdata = k_q;
		unique case (state_q)
			ST_FILL: begin
				s_we = 1'b1;
			end
			ST_KACC: begin
				s_addr = acc_nxt;
			end
			ST_KWK: begin
				s_we    = 1'b1;
				s_wdata = s_rdata;
			end
			ST_KWA: begin
				s_we    = 1'b1;
				s_addr  = j_q;
				s_wdata = a_q;
			end
			ST_PRD_I: begin
				s_addr = i_q;
			end
			ST_PRD_J: begin
				s_addr = jp_nxt;
			end
			ST_PRD_T: begin
				s_addr = t_nxt;
			end
			ST_PWR_I: begin
				s_we    = 1'b1;
				s_addr  = i_q;
				s_wdata = b_q;
			end
			ST_PWR_J: begin
				s_we    = 1'b1;
				s_addr  = j_q;
				s_wdata = a_q;
			end
			default: begin
				s_we = 1'b0;
			end
		endcase
	end

	// key store port: loads only while idle, schedule reads otherwise
	always_comb begin
		k_we   = idle && cmd.valid && (cmd.mode == rc4_pkg::MODE_LOAD) && key_in_range;
		k_addr = idle ? cmd.key_index[KEY_AW-1:0] : kk_q;
	end

	always_comb begin
		res.valid       = 1'b0;
		res.stream_byte = 8'd0;
		res.status      = rc4_pkg::STATUS_OK;
		if (state_q == ST_NKEY && out_free) begin
			res.valid  = 1'b1;
			res.status = rc4_pkg::STATUS_NOT_KEYED;
		end else if (state_q == ST_PWR_J && out_free) begin
			res.valid = 1'b1;
			priority if (t_q == j_q) begin
				res.stream_byte = a_q;
			end else if (t_q == i_q) begin
				res.stream_byte = b_q;
			end else begin
				res.stream_byte = c_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= 8'd0;
			kk_q    <= '0;
			i_q     <= 8'd0;
			j_q     <= 8'd0;
			keyed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						if (cmd.mode == rc4_pkg::MODE_SCHED) begin
							k_q     <= 8'd0;
							state_q <= ST_FILL;
						end else if (cmd.mode == rc4_pkg::MODE_STREAM) begin
							if (keyed_q) begin
								i_q     <= i_q + 8'd1;
								state_q <= ST_PRD_I;
							end else begin
								state_q <= ST_NKEY;
							end
						end
					end
				end
				ST_FILL: begin
					k_q <= k_q + 8'd1;
					if (k_q == 8'hff) begin
						kk_q    <= '0;
						j_q     <= 8'd0;
						state_q <= ST_KRD;
					end
				end
				ST_KRD: begin
					state_q <= ST_KACC;
				end
				ST_KACC: begin
					j_q     <= acc_nxt;
					state_q <= ST_KWK;
				end
				ST_KWK: begin
					state_q <= ST_KWA;
				end
				ST_KWA: begin
					k_q  <= k_q + 8'd1;
					kk_q <= kk_wrap ? '0 : kk_q + KEY_AW'(1);
					if (k_q == 8'hff) begin
						i_q     <= 8'd0;
						j_q     <= 8'd0;
						keyed_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_KRD;
					end
				end
				ST_PRD_I: begin
					state_q <= ST_PRD_J;
				end
				ST_PRD_J: begin
					j_q     <= jp_nxt;
					state_q <= ST_PRD_T;
				end
				ST_PRD_T: begin
					state_q <= ST_PWR_I;
				end
				ST_PWR_I: begin
					state_q <= ST_PWR_J;
				end
				ST_PWR_J: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_NKEY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_KACC, ST_PRD_J: begin
				a_q <= s_rdata;
			end
			ST_PRD_T: begin
				b_q <= s_rdata;
				t_q <= t_nxt;
			end
			ST_PWR_I: begin
				c_q <= s_rdata;
			end
			default: begin
			end
		endcase
	end

	rc4_ram #(
		.WIDTH (8),
		.DEPTH (rc4_pkg::SBOX_DEPTH)
	) u_sbox (
		.clk   (clk),
		.we    (s_we),
		.addr  (s_addr),
		.wdata (s_wdata),
		.rdata (s_rdata)
	);

	rc4_ram #(
		.WIDTH (8),
		.DEPTH (KEY_DEPTH)
	) u_key (
		.clk   (clk),
		.we    (k_we),
		.addr  (k_addr),
		.wdata (cmd.key_byte),
		.rdata (k_rdata)
	);

endmodule
